@@ sv/sfcd_pkg.sv @@
package sfcd_pkg;

    // frame geometry and queue size
    localparam int FRAME_BYTES_DEF = 67;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int FIELD_COUNT     = 21;
    localparam int FIELD_IW        = 5;
    localparam int FIELD_VW        = 64;

    // configuration port
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 16;

    localparam logic [CFG_IW-1:0] REG_FIRST_SYNC      = 3'd0;
    localparam logic [CFG_IW-1:0] REG_SECOND_SYNC     = 3'd1;
    localparam logic [CFG_IW-1:0] REG_FORMAT_VERSION  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_EXPECTED_ID     = 3'd3;
    localparam logic [CFG_IW-1:0] REG_EXPECTED_LENGTH = 3'd4;

    // crc-16/x-25 in reflected form
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_XOROUT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_REFL = 16'h8408;

    localparam logic [FIELD_IW-1:0] LAST_FIELD = 5'(FIELD_COUNT - 1);

    typedef struct packed {
        logic [7:0]  first_sync;
        logic [7:0]  second_sync;
        logic [7:0]  format_version;
        logic [15:0] expected_id;
        logic [15:0] expected_length;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        first_sync:      8'd170,
        second_sync:     8'd0,
        format_version:  8'd0,
        expected_id:     16'd0,
        expected_length: 16'd55
    };

    // byte position of each payload field inside the frame
    function automatic logic [6:0] field_offset(input logic [FIELD_IW-1:0] f);
        logic [6:0] r;
        case (f)
            5'd0:    r = 7'd10;
            5'd1:    r = 7'd11;
            5'd2:    r = 7'd19;
            5'd3:    r = 7'd23;
            5'd4:    r = 7'd27;
            5'd5:    r = 7'd31;
            5'd6:    r = 7'd33;
            5'd7:    r = 7'd35;
            5'd8:    r = 7'd37;
            5'd9:    r = 7'd39;
            5'd10:   r = 7'd41;
            5'd11:   r = 7'd43;
            5'd12:   r = 7'd45;
            5'd13:   r = 7'd47;
            5'd14:   r = 7'd49;
            5'd15:   r = 7'd51;
            5'd16:   r = 7'd53;
            5'd17:   r = 7'd55;
            5'd18:   r = 7'd59;
            5'd19:   r = 7'd61;
            5'd20:   r = 7'd63;
            default: r = 7'd10;
        endcase
        return r;
    endfunction

    // field size in bytes, minus one
    function automatic logic [2:0] field_len_m1(input logic [FIELD_IW-1:0] f);
        logic [2:0] r;
        case (f)
            5'd0:    r = 3'd0;
            5'd1:    r = 3'd7;
            5'd2:    r = 3'd3;
            5'd3:    r = 3'd3;
            5'd4:    r = 3'd3;
            5'd17:   r = 3'd3;
            default: r = 3'd1;
        endcase
        return r;
    endfunction

endpackage

@@ sv/sync_frame_crc16_deframer_unit.sv @@
// Sync-byte frame deframer with CRC-16/X-25 check. Bytes enter through a small
// queue (QUEUE_DEPTH deep) and, while the engine is idle, are stored one per
// cycle into a circular window memory of FRAME_BYTES entries. Once the window
// is full, the frame engine reads it back through the single memory read port,
// one byte per cycle: a sync mismatch is found once the second byte is read,
// while a sync match costs a full pass over the window (header compare and
// byte-wise CRC in the same pass). A valid frame then emits 21 fields: each
// payload byte is fetched and placed in the field word, and each field goes to
// the output register, waiting while the output stalls. While a judgement runs,
// further bytes wait in the queue. After a rejected frame the window slides by
// one byte (sync mismatch) or two (sync matched, later check failed).
// Configuration writes are taken at any time but belong to idle periods.
module sync_frame_crc16_deframer_unit #(
    parameter int FRAME_BYTES = sfcd_pkg::FRAME_BYTES_DEF,
    parameter int QUEUE_DEPTH = sfcd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sfcd_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [sfcd_pkg::CFG_DW-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_rx_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sfcd_pkg::FIELD_IW-1:0] o_field_index,
    output logic [sfcd_pkg::FIELD_VW-1:0] o_field_value,
    output logic                          o_last_field
);
    import sfcd_pkg::*;

    t_cfg       w_cfg;
    logic       w_q_valid;
    logic       w_q_ready;
    logic [7:0] w_q_byte;

    // request intake and configuration
    sfcd_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_rx_byte   (i_rx_byte),
        .o_q_valid   (w_q_valid),
        .i_q_ready   (w_q_ready),
        .o_q_byte    (w_q_byte)
    );

    // window, frame judgement and field output
    sfcd_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_q_valid     (w_q_valid),
        .o_q_ready     (w_q_ready),
        .i_q_byte      (w_q_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_field_index (o_field_index),
        .o_field_value (o_field_value),
        .o_last_field  (o_last_field)
    );

endmodule

@@ sv/sfcd_front.sv @@
module sfcd_front #(
    parameter int QUEUE_DEPTH = sfcd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [sfcd_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [sfcd_pkg::CFG_DW-1:0] i_cfg_data,
    output sfcd_pkg::t_cfg              o_cfg,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [7:0]                  i_rx_byte,
    output logic                        o_q_valid,
    input  logic                        i_q_ready,
    output logic [7:0]                  o_q_byte
);
    import sfcd_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

    t_cfg r_cfg;

    logic [7:0]    r_q_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_push;
    logic          w_pop;

    // configuration registers, writes always taken
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FIRST_SYNC:      r_cfg.first_sync      <= i_cfg_data[7:0];
                REG_SECOND_SYNC:     r_cfg.second_sync     <= i_cfg_data[7:0];
                REG_FORMAT_VERSION:  r_cfg.format_version  <= i_cfg_data[7:0];
                REG_EXPECTED_ID:     r_cfg.expected_id     <= i_cfg_data;
                REG_EXPECTED_LENGTH: r_cfg.expected_length <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // byte queue toward the frame engine
    assign o_in_ready = (r_count != CNT_FULL);
    assign o_q_valid  = (r_count != '0);
    assign o_q_byte   = r_q_mem[r_rd_ptr];
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_mem[r_wr_ptr] <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ sv/sfcd_crc.sv @@
module sfcd_crc (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_init,
    input  logic        i_en,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);
    import sfcd_pkg::*;

    logic [15:0] r_crc;
    logic [15:0] n_crc;

    // one byte per cycle while enabled, lsb first
    always_comb begin
        n_crc = r_crc ^ {8'h00, i_byte};
        for (int b = 0; b < 8; b++) begin
            n_crc = n_crc[0] ? ((n_crc >> 1) ^ CRC_POLY_REFL) : (n_crc >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else if (i_init) begin
            r_crc <= CRC_INIT;
        end else if (i_en) begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

@@ sv/sfcd_back.sv @@
module sfcd_back #(
    parameter int FRAME_BYTES = sfcd_pkg::FRAME_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sfcd_pkg::t_cfg                i_cfg,
    input  logic                          i_q_valid,
    output logic                          o_q_ready,
    input  logic [7:0]                    i_q_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sfcd_pkg::FIELD_IW-1:0] o_field_index,
    output logic [sfcd_pkg::FIELD_VW-1:0] o_field_value,
    output logic                          o_last_field
);
    import sfcd_pkg::*;

    localparam int AW = $clog2(FRAME_BYTES);
    localparam int CW = $clog2(FRAME_BYTES + 1);

    localparam logic [CW:0]   FB_WIDE     = (CW + 1)'(FRAME_BYTES);
    localparam logic [CW-1:0] FB_CNT      = CW'(FRAME_BYTES);
    localparam logic [CW-1:0] FB_LAST     = CW'(FRAME_BYTES - 1);
    localparam logic [CW-1:0] IDX_CRC_END = CW'(FRAME_BYTES - 3);
    localparam logic [CW-1:0] IDX_CRC_LO  = CW'(FRAME_BYTES - 2);
    localparam logic [CW-1:0] IDX_CRC_HI  = CW'(FRAME_BYTES - 1);
    localparam logic [CW-1:0] IDX_SYNC0   = CW'(0);
    localparam logic [CW-1:0] IDX_SYNC1   = CW'(1);
    localparam logic [CW-1:0] IDX_VER     = CW'(2);
    localparam logic [CW-1:0] IDX_ID_LO   = CW'(3);
    localparam logic [CW-1:0] IDX_ID_HI   = CW'(4);
    localparam logic [CW-1:0] IDX_LEN_LO  = CW'(5);
    localparam logic [CW-1:0] IDX_LEN_HI  = CW'(6);
    localparam logic [CW-1:0] DROP_ONE    = CW'(1);
    localparam logic [CW-1:0] DROP_TWO    = CW'(2);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_ERD   = 3'd2;
    localparam logic [2:0] ST_EWAIT = 3'd3;
    localparam logic [2:0] ST_EPUT  = 3'd4;

    // circular window position of a frame offset
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] ofs);
        logic [CW:0] s;
        s = (CW + 1)'(base) + (CW + 1)'(ofs);
        if (s >= FB_WIDE) begin
            s = s - FB_WIDE;
        end
        return s[AW-1:0];
    endfunction

    logic [7:0]          r_win [FRAME_BYTES];
    logic [7:0]          r_rd_data;

    logic [2:0]          r_state, n_state;
    logic [AW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_fill, n_fill;
    logic [CW-1:0]       r_ra, n_ra;
    logic                r_rv, n_rv;
    logic [CW-1:0]       r_ri, n_ri;
    logic                r_sync_bad, n_sync_bad;
    logic                r_hdr_bad, n_hdr_bad;
    logic [7:0]          r_lo, n_lo;
    logic [FIELD_IW-1:0] r_f, n_f;
    logic [2:0]          r_j, n_j;
    logic [FIELD_VW-1:0] r_acc, n_acc;

    logic                r_out_valid;
    logic [FIELD_IW-1:0] r_out_index;
    logic [FIELD_VW-1:0] r_out_value;
    logic                r_out_last;

    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [AW-1:0]       w_raddr;
    logic                w_crc_init;
    logic                w_crc_en;
    logic [15:0]         w_crc;
    logic                w_load_out;
    logic [CW-1:0]       w_field_ofs;

    sfcd_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_init  (w_crc_init),
        .i_en    (w_crc_en),
        .i_byte  (r_rd_data),
        .o_crc   (w_crc)
    );

    assign w_waddr     = wrap_add(r_head, r_fill);
    assign w_field_ofs = CW'(field_offset(r_f)) + CW'(r_j);
    assign o_q_ready   = (r_state == ST_IDLE);

    // window memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_win[w_waddr] <= i_q_byte;
        end
        r_rd_data <= r_win[w_raddr];
    end

    // frame engine
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_fill     = r_fill;
        n_ra       = r_ra;
        n_rv       = 1'b0;
        n_ri       = r_ri;
        n_sync_bad = r_sync_bad;
        n_hdr_bad  = r_hdr_bad;
        n_lo       = r_lo;
        n_f        = r_f;
        n_j        = r_j;
        n_acc      = r_acc;
        w_we       = 1'b0;
        w_raddr    = wrap_add(r_head, r_ra);
        w_crc_init = 1'b0;
        w_crc_en   = 1'b0;
        w_load_out = 1'b0;

        case (r_state)
            // store the next byte, judge once the window is full
            ST_IDLE: begin
                if (i_q_valid) begin
                    w_we   = 1'b1;
                    n_fill = r_fill + 1'b1;
                    if (r_fill == FB_LAST) begin
                        n_state    = ST_SCAN;
                        n_ra       = '0;
                        n_sync_bad = 1'b0;
                        n_hdr_bad  = 1'b0;
                        w_crc_init = 1'b1;
                    end
                end
            end

            // stream the window once: header checks and crc
            ST_SCAN: begin
                if (r_ra != FB_CNT) begin
                    n_rv = 1'b1;
                    n_ri = r_ra;
                    n_ra = r_ra + 1'b1;
                end
                if (r_rv) begin
                    if (r_ri <= IDX_CRC_END) begin
                        w_crc_en = 1'b1;
                    end
                    case (r_ri)
                        IDX_SYNC0: begin
                            n_sync_bad = (r_rd_data != i_cfg.first_sync);
                        end
                        IDX_SYNC1: begin
                            if (r_sync_bad || r_rd_data != i_cfg.second_sync) begin
                                n_head  = wrap_add(r_head, DROP_ONE);
                                n_fill  = r_fill - DROP_ONE;
                                n_state = ST_IDLE;
                            end
                        end
                        IDX_VER: begin
                            if (r_rd_data != i_cfg.format_version) n_hdr_bad = 1'b1;
                        end
                        IDX_ID_LO: begin
                            if (r_rd_data != i_cfg.expected_id[7:0]) n_hdr_bad = 1'b1;
                        end
                        IDX_ID_HI: begin
                            if (r_rd_data != i_cfg.expected_id[15:8]) n_hdr_bad = 1'b1;
                        end
                        IDX_LEN_LO: begin
                            if (r_rd_data != i_cfg.expected_length[7:0]) n_hdr_bad = 1'b1;
                        end
                        IDX_LEN_HI: begin
                            if (r_rd_data != i_cfg.expected_length[15:8]) n_hdr_bad = 1'b1;
                        end
                        IDX_CRC_LO: begin
                            n_lo = r_rd_data;
                        end
                        IDX_CRC_HI: begin
                            if (r_hdr_bad || {r_rd_data, r_lo} != (w_crc ^ CRC_XOROUT)) begin
                                n_head  = wrap_add(r_head, DROP_TWO);
                                n_fill  = r_fill - DROP_TWO;
                                n_state = ST_IDLE;
                            end else begin
                                n_f     = '0;
                                n_j     = '0;
                                n_acc   = '0;
                                n_state = ST_ERD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // fetch one byte of the current field
            ST_ERD: begin
                w_raddr = wrap_add(r_head, w_field_ofs);
                n_state = ST_EWAIT;
            end

            // place it little-endian in the field word
            ST_EWAIT: begin
                n_acc[{r_j, 3'b000} +: 8] = r_rd_data;
                if (r_j == field_len_m1(r_f)) begin
                    n_state = ST_EPUT;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = ST_ERD;
                end
            end

            // hand the field to the output register
            ST_EPUT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load_out = 1'b1;
                    n_acc      = '0;
                    n_j        = '0;
                    if (r_f == LAST_FIELD) begin
                        // whole frame consumed, head wraps onto itself
                        n_fill  = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_f     = r_f + 1'b1;
                        n_state = ST_ERD;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_fill  <= '0;
            r_rv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_fill  <= n_fill;
            r_rv    <= n_rv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ra       <= n_ra;
        r_ri       <= n_ri;
        r_sync_bad <= n_sync_bad;
        r_hdr_bad  <= n_hdr_bad;
        r_lo       <= n_lo;
        r_f        <= n_f;
        r_j        <= n_j;
        r_acc      <= n_acc;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_index <= r_f;
            r_out_value <= r_acc;
            r_out_last  <= (r_f == LAST_FIELD);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_field_index = r_out_index;
    assign o_field_value = r_out_value;
    assign o_last_field  = r_out_last;

endmodule

@@ verif/sync_frame_crc16_deframer_unit_tb.sv @@
`timescale 1ns / 1ps

module sync_frame_crc16_deframer_unit_tb;
    import sfcd_pkg::*;

    localparam int FRAME_LEN      = FRAME_BYTES_DEF;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 500;
    localparam int STALL_LIMIT    = 4000;
    localparam int PRESSURE_BYTES = 6;

    // indexes past the last register, writes there must be dropped
    localparam logic [CFG_IW-1:0] REG_UNUSED_LO = 3'd5;
    localparam int                REG_UNUSED_N  = 3;

    // payload field layout: first byte and size in bytes
    localparam int FLD_POS [FIELD_COUNT] = '{
        10, 11, 19, 23, 27, 31, 33, 35, 37, 39, 41,
        43, 45, 47, 49, 51, 53, 55, 59, 61, 63
    };
    localparam int FLD_LEN [FIELD_COUNT] = '{
        1, 8, 4, 4, 4, 2, 2, 2, 2, 2, 2,
        2, 2, 2, 2, 2, 2, 4, 2, 2, 2
    };

    typedef enum int {
        SEG_GOOD,
        SEG_BAD_SYNC,
        SEG_BAD_VERSION,
        SEG_BAD_ID,
        SEG_BAD_LENGTH,
        SEG_BAD_CRC,
        SEG_TRUNCATED,
        SEG_NOISE
    } t_seg_kind;

    typedef struct packed {
        logic [FIELD_IW-1:0] idx;
        logic [FIELD_VW-1:0] value;
        logic                last;
    } t_field_rec;

    // clock and dut ports
    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_valid   = 1'b0;
    logic [CFG_IW-1:0]   i_cfg_index   = '0;
    logic [CFG_DW-1:0]   i_cfg_data    = '0;
    logic                i_in_valid    = 1'b0;
    logic [7:0]          i_rx_byte     = '0;
    logic                i_out_ready   = 1'b0;
    logic                o_cfg_ready;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [FIELD_IW-1:0] o_field_index;
    logic [FIELD_VW-1:0] o_field_value;
    logic                o_last_field;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_armed     = 1'b0;

    always #2 i_clk = ~i_clk;

    sync_frame_crc16_deframer_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_field_index (o_field_index),
        .o_field_value (o_field_value),
        .o_last_field  (o_last_field)
    );

    // crc-16/x-25 over the frame body, reflected bitwise form
    function automatic logic [15:0] x25_crc(input logic [7:0] bytes [$]);
        logic [15:0] crc;
        crc = CRC_INIT;
        for (int i = 0; i < FRAME_LEN - 2; i++) begin
            crc = crc ^ {8'h00, bytes[i]};
            for (int b = 0; b < 8; b++) begin
                if (crc[0]) begin
                    crc = (crc >> 1) ^ CRC_POLY_REFL;
                end else begin
                    crc = crc >> 1;
                end
            end
        end
        return crc ^ CRC_XOROUT;
    endfunction

    class t_frame_scoreboard;
        t_cfg       regs;
        logic [7:0] win [$];
        t_field_rec field_q [$];
        int         fields_predicted;
        int         errors;

        function new();
            regs             = CFG_RESET;
            fields_predicted = 0;
            errors           = 0;
        endfunction

        function void set_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] d);
            case (idx)
                REG_FIRST_SYNC:      regs.first_sync      = d[7:0];
                REG_SECOND_SYNC:     regs.second_sync     = d[7:0];
                REG_FORMAT_VERSION:  regs.format_version  = d[7:0];
                REG_EXPECTED_ID:     regs.expected_id     = d;
                REG_EXPECTED_LENGTH: regs.expected_length = d;
                default: ;
            endcase
        endfunction

        function void slide(input int n);
            repeat (n) win.delete(0);
        endfunction

        // window update and frame judgement for one accepted byte
        function void absorb_byte(input logic [7:0] b);
            logic [15:0] id;
            logic [15:0] len;
            logic [15:0] got;
            t_field_rec  rec;
            if (win.size() >= FRAME_LEN) win.delete(0);
            win = {win, b};
            if (win.size() < FRAME_LEN) return;
            if (win[0] != regs.first_sync || win[1] != regs.second_sync) begin
                slide(1);
                return;
            end
            id  = {win[4], win[3]};
            len = {win[6], win[5]};
            if (win[2] != regs.format_version || id != regs.expected_id ||
                len != regs.expected_length) begin
                slide(2);
                return;
            end
            got = {win[FRAME_LEN-1], win[FRAME_LEN-2]};
            if (got != x25_crc(win)) begin
                slide(2);
                return;
            end
            for (int f = 0; f < FIELD_COUNT; f++) begin
                rec.idx   = FIELD_IW'(f);
                rec.value = '0;
                for (int k = 0; k < FLD_LEN[f]; k++) begin
                    rec.value = rec.value | (64'(win[FLD_POS[f] + k]) << (8 * k));
                end
                rec.last = (f == FIELD_COUNT - 1);
                field_q = {field_q, rec};
            end
            fields_predicted += FIELD_COUNT;
            win.delete();
        endfunction

        function void check_field(input logic [FIELD_IW-1:0] idx,
                                  input logic [FIELD_VW-1:0] value, input logic last);
            t_field_rec e;
            if (field_q.size() == 0) begin
                $error("unexpected field: field_index %0d field_value %h", idx, value);
                errors++;
                return;
            end
            e = field_q[0];
            field_q.delete(0);
            if (idx !== e.idx) begin
                $error("field_index expected %0d actual %0d", e.idx, idx);
                errors++;
            end
            if (value !== e.value) begin
                $error("field_value expected %h actual %h", e.value, value);
                errors++;
            end
            if (last !== e.last) begin
                $error("last_field expected %0b actual %0b", e.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return field_q.size();
        endfunction
    endclass

    t_frame_scoreboard board;

    // output side: random stalls plus one long hold-off
    initial begin : out_side
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_armed && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // result check on each accepted request
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_field(o_field_index, o_field_value, o_last_field);
        end
    end

    // no accepted request on any channel for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.set_reg(idx, d);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.absorb_byte(b);
    endtask

    // one frame built from the current settings, possibly damaged, or noise
    task automatic send_segment(input t_seg_kind kind);
        logic [7:0]  frm [$];
        logic [15:0] crc;
        logic [7:0]  nz;
        t_cfg        c;
        int          fill;
        int          pos;
        int          cut;
        if (kind == SEG_NOISE) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            return;
        end
        c    = board.regs;
        fill = $urandom_range(9);
        nz   = 8'($urandom_range(1, 255));
        frm  = {c.first_sync, c.second_sync, c.format_version,
                c.expected_id[7:0], c.expected_id[15:8],
                c.expected_length[7:0], c.expected_length[15:8]};
        for (int i = 7; i < FRAME_LEN - 2; i++) begin
            frm = {frm, (fill == 0 ? 8'h00 : fill == 1 ? 8'hFF : 8'($urandom))};
        end
        // header damage
        pos = -1;
        case (kind)
            SEG_BAD_SYNC:    pos = $urandom_range(1);
            SEG_BAD_VERSION: pos = 2;
            SEG_BAD_ID:      pos = 3 + $urandom_range(1);
            SEG_BAD_LENGTH:  pos = 5 + $urandom_range(1);
            default: ;
        endcase
        if (pos >= 0) frm[pos] = frm[pos] ^ nz;
        crc = x25_crc(frm);
        if (kind == SEG_BAD_CRC) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
        frm = {frm, crc[7:0], crc[15:8]};
        cut = (kind == SEG_TRUNCATED) ? $urandom_range(3, FRAME_LEN - 1) : FRAME_LEN;
        for (int i = 0; i < cut; i++) send_byte(frm[i]);
    endtask

    // wait until every field is out and the engine has gone quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (board.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_all(input logic [CFG_DW-1:0] fs, input logic [CFG_DW-1:0] ss,
                             input logic [CFG_DW-1:0] fv, input logic [CFG_DW-1:0] id,
                             input logic [CFG_DW-1:0] len);
        write_reg(REG_FIRST_SYNC, fs);
        write_reg(REG_SECOND_SYNC, ss);
        write_reg(REG_FORMAT_VERSION, fv);
        write_reg(REG_EXPECTED_ID, id);
        write_reg(REG_EXPECTED_LENGTH, len);
        write_reg(REG_UNUSED_LO + CFG_IW'($urandom_range(REG_UNUSED_N - 1)),
                  CFG_DW'($urandom));
    endtask

    initial begin : main_seq
        logic [7:0] directed [$];
        board = new();
        directed = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE,
                     8'hAA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37, 8'h00, 8'hAA,
                     8'hAA, 8'hFF, 8'h00, 8'hAA};

        // reset
        i_rst_n <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ignored register indexes, then a partly filled window, no idling
        for (int k = 0; k < REG_UNUSED_N; k++) begin
            write_reg(REG_UNUSED_LO + CFG_IW'(k), CFG_DW'($urandom));
        end
        foreach (directed[i]) send_byte(directed[i]);

        // sender idle while a frame goes in, receiver stalling while it comes out
        send_idle_pct = 65;
        send_segment(SEG_GOOD);
        send_idle_pct  = 0;
        recv_stall_pct = 65;
        settle();

        // new settings, light idling on both sides and one long output hold-off
        write_all(CFG_DW'($urandom), CFG_DW'($urandom), CFG_DW'($urandom),
                  CFG_DW'($urandom), CFG_DW'($urandom));
        send_idle_pct  = 8;
        recv_stall_pct = 8;
        hold_armed     = 1'b1;
        send_segment(SEG_GOOD);
        // keep offering bytes so the queue fills behind the held output
        repeat (PRESSURE_BYTES) send_byte(8'($urandom));

        settle();
        if (board.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ sync_frame_crc16_deframer_unit.f @@
sv/sfcd_pkg.sv
sv/sfcd_front.sv
sv/sfcd_crc.sv
sv/sfcd_back.sv
sv/sync_frame_crc16_deframer_unit.sv
verif/sync_frame_crc16_deframer_unit_tb.sv
